[design/ggvt_pkg.sv]
// shared types and constants for the gossip group view table
// no dependencies
package ggvt_pkg;

  localparam int GROUP_W     = 11;
  localparam int POS_FRAC    = 16;
  localparam int POS_W       = POS_FRAC + 1;
  localparam int KEY_W       = 16;
  localparam int IDENT_W     = 16;
  localparam int AGE_W       = 8;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_GROUPS  = 1024;
  localparam int VIEW_SIZE_W = 6;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REPL_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_POS = 3'd4;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PEER  = 2'd1,
    OP_END   = 2'd2,
    OP_LOCAL = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AGE_RD,
    S_AGE_WR,
    S_REC_MUL,
    S_REC_CHK,
    S_REC_RD,
    S_REC_EV,
    S_REC_WR,
    S_END_RD,
    S_END_MUL,
    S_END_CHK,
    S_END_ADJ,
    S_SELF_MUL,
    S_SELF_FIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [IDENT_W-1:0] ident;
    logic [AGE_W-1:0]   age;
    logic [POS_W-1:0]   pos;
  } entry_t;

  typedef struct packed {
    op_e                  op;
    logic [KEY_W-1:0]     key;
    logic [IDENT_W-1:0]   ident;
    logic [AGE_W-1:0]     age;
    logic [POS_W-1:0]     pos;
    logic [GROUP_W-1:0]   gc;
  } item_t;

endpackage

[design/ggvt_group_unit.sv]
// shared group index unit: ceil(groups * position), at least one
// registered multiply, then round up and clamp; uses ggvt_pkg
module ggvt_group_unit (
  input  logic                          clk_i,
  input  logic [ggvt_pkg::GROUP_W-1:0]  groups_i,
  input  logic [ggvt_pkg::POS_W-1:0]    pos_i,
  output logic [ggvt_pkg::GROUP_W-1:0]  group_o
);

  localparam int ProdW = ggvt_pkg::GROUP_W + ggvt_pkg::POS_W;
  localparam logic [ggvt_pkg::POS_W-1:0] One = ggvt_pkg::POS_W'(1) << ggvt_pkg::POS_FRAC;

  logic [ggvt_pkg::POS_W-1:0] pos_clamp;
  logic [ProdW-1:0]           prod_q;
  logic [ProdW-1:0]           rounded;
  logic [ggvt_pkg::GROUP_W-1:0] grp;

  assign pos_clamp = (pos_i > One) ? One : pos_i;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(groups_i) * ProdW'(pos_clamp);
  end

  always_comb begin
    rounded = prod_q + ProdW'(One - ggvt_pkg::POS_W'(1));
    grp     = ggvt_pkg::GROUP_W'(rounded >> ggvt_pkg::POS_FRAC);
    group_o = (grp == '0) ? ggvt_pkg::GROUP_W'(1) : grp;
  end

endmodule

[design/gossip_group_view_table.sv]
// gossip group view table: one transaction in flight, a sequencer sweeps the view memory
// start ages each valid entry; a record passing the group filter scans every entry, then writes;
// end checks each entry, then adjusts; all through one group unit and memory port
// result waits in an output register; end holds in emit while that register is still full
// asynchronous active-low reset empties the view (valid bits) and loads config defaults
// depends on ggvt_pkg and ggvt_group_unit
module gossip_group_view_table #(
  parameter int VIEW_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ggvt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ggvt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // peer_key, peer_ident, peer_age, peer_position, peer_group_count, zero pad
  input  logic [ggvt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // group_count, own_group, view_size, zero pad
  output logic [ggvt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int AW   = (VIEW_DEPTH > 1) ? $clog2(VIEW_DEPTH) : 1;
  localparam int CW   = $clog2(VIEW_DEPTH + 1);
  localparam int CmpW = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int GW   = ggvt_pkg::GROUP_W;
  localparam logic [AW-1:0] LastIdx = AW'(VIEW_DEPTH - 1);

  ggvt_pkg::state_e state_q, state_d;
  ggvt_pkg::entry_t mem [VIEW_DEPTH];
  ggvt_pkg::entry_t rd_data_q, wr_data, hit_q, hit_d;
  ggvt_pkg::item_t  item_q, item_d;

  logic [VIEW_DEPTH-1:0] valid_q, valid_d;
  logic [AW-1:0] idx_q, idx_d, hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, wr_addr;
  logic found_q, found_d, free_q, free_d, mem_we;
  logic [CW-1:0] size_q, size_d;
  logic [GW-1:0] groups_q, groups_d, my_group_q, my_group_d, seen_q, seen_d, grp, t_grp;
  logic [GW:0]   dbl;
  logic first_q, first_d;
  logic [7:0] rmin_q, rmax_q, alim_q;
  logic [ggvt_pkg::IDENT_W-1:0] self_id_q;
  logic [ggvt_pkg::POS_W-1:0]   self_pos_q, unit_pos;
  logic out_valid_q, out_valid_d, out_load, last;
  logic [GW-1:0] out_gc_q, out_own_q;
  logic [ggvt_pkg::VIEW_SIZE_W-1:0] out_size_q;
  logic [CmpW-1:0] size_p1;
  ggvt_pkg::item_t in_item;

  assign in_item.op    = ggvt_pkg::op_e'(s_axis_tuser);
  assign in_item.key   = s_axis_tdata[15:0];
  assign in_item.ident = s_axis_tdata[31:16];
  assign in_item.age   = s_axis_tdata[39:32];
  assign in_item.pos   = s_axis_tdata[56:40];
  assign in_item.gc    = s_axis_tdata[67:57];

  assign s_axis_tready = (state_q == ggvt_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_size_q, out_own_q, out_gc_q};
  assign last          = (idx_q == LastIdx);
  assign size_p1       = CmpW'(size_q) + CmpW'(1);
  assign out_load      = (state_q == ggvt_pkg::S_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    unique case (state_q)
      ggvt_pkg::S_REC_MUL, ggvt_pkg::S_REC_CHK: unit_pos = item_q.pos;
      ggvt_pkg::S_SELF_MUL, ggvt_pkg::S_SELF_FIN: unit_pos = self_pos_q;
      default: unit_pos = rd_data_q.pos;
    endcase
  end

  ggvt_group_unit u_group (
    .clk_i    (clk_i),
    .groups_i (groups_q),
    .pos_i    (unit_pos),
    .group_o  (grp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ggvt_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_item.op)
            ggvt_pkg::OP_START: state_d = ggvt_pkg::S_AGE_RD;
            ggvt_pkg::OP_PEER:  state_d = ggvt_pkg::S_REC_MUL;
            ggvt_pkg::OP_LOCAL: state_d = ggvt_pkg::S_REC_MUL;
            ggvt_pkg::OP_END:   state_d = ggvt_pkg::S_END_RD;
          endcase
        end
      end
      ggvt_pkg::S_AGE_RD:  state_d = ggvt_pkg::S_AGE_WR;
      ggvt_pkg::S_AGE_WR:  state_d = last ? ggvt_pkg::S_IDLE : ggvt_pkg::S_AGE_RD;
      ggvt_pkg::S_REC_MUL: state_d = ggvt_pkg::S_REC_CHK;
      ggvt_pkg::S_REC_CHK: begin
        state_d = (grp == my_group_q && item_q.ident != self_id_q) ?
                  ggvt_pkg::S_REC_RD : ggvt_pkg::S_IDLE;
      end
      ggvt_pkg::S_REC_RD:  state_d = ggvt_pkg::S_REC_EV;
      ggvt_pkg::S_REC_EV:  state_d = last ? ggvt_pkg::S_REC_WR : ggvt_pkg::S_REC_RD;
      ggvt_pkg::S_REC_WR:  state_d = ggvt_pkg::S_IDLE;
      ggvt_pkg::S_END_RD:  state_d = ggvt_pkg::S_END_MUL;
      ggvt_pkg::S_END_MUL: state_d = ggvt_pkg::S_END_CHK;
      ggvt_pkg::S_END_CHK: state_d = last ? ggvt_pkg::S_END_ADJ : ggvt_pkg::S_END_RD;
      ggvt_pkg::S_END_ADJ: state_d = ggvt_pkg::S_SELF_MUL;
      ggvt_pkg::S_SELF_MUL: state_d = ggvt_pkg::S_SELF_FIN;
      ggvt_pkg::S_SELF_FIN: state_d = ggvt_pkg::S_EMIT;
      ggvt_pkg::S_EMIT:    state_d = out_load ? ggvt_pkg::S_IDLE : ggvt_pkg::S_EMIT;
      default:             state_d = ggvt_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    item_d     = item_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    found_d    = found_q;
    free_d     = free_q;
    size_d     = size_q;
    groups_d   = groups_q;
    my_group_d = my_group_q;
    seen_d     = seen_q;
    first_d    = first_q;
    out_valid_d = out_valid_q;
    mem_we     = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_data_q;
    t_grp      = groups_q;
    dbl        = '0;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      ggvt_pkg::S_IDLE: begin
        idx_d   = '0;
        found_d = 1'b0;
        free_d  = 1'b0;
        size_d  = '0;
        if (s_axis_tvalid) begin
          item_d = in_item;
          if (in_item.op == ggvt_pkg::OP_START) seen_d = GW'(1);
          if (in_item.op == ggvt_pkg::OP_PEER && first_q && in_item.gc > groups_q)
            seen_d = in_item.gc;
        end
      end
      ggvt_pkg::S_AGE_WR: begin
        if (valid_q[idx_q] && rd_data_q.age != ggvt_pkg::AGE_MAX) begin
          mem_we      = 1'b1;
          wr_data.age = rd_data_q.age + ggvt_pkg::AGE_W'(1);
        end
        idx_d = idx_q + AW'(1);
      end
      ggvt_pkg::S_REC_EV: begin
        if (valid_q[idx_q] && rd_data_q.key == item_q.key && !found_q) begin
          found_d   = 1'b1;
          hit_d     = rd_data_q;
          hit_idx_d = idx_q;
        end
        if (!valid_q[idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        idx_d = idx_q + AW'(1);
      end
      ggvt_pkg::S_REC_WR: begin
        wr_data.key   = item_q.key;
        wr_data.ident = item_q.ident;
        wr_data.age   = item_q.age;
        wr_data.pos   = item_q.pos;
        if (found_q) begin
          wr_addr = hit_idx_q;
          mem_we  = (hit_q.age > item_q.age);
          if (item_q.op == ggvt_pkg::OP_LOCAL) begin
            wr_data.ident = hit_q.ident;
            wr_data.pos   = hit_q.pos;
          end
        end else if (free_q) begin
          wr_addr             = free_idx_q;
          mem_we              = 1'b1;
          valid_d[free_idx_q] = 1'b1;
        end
      end
      ggvt_pkg::S_END_CHK: begin
        if (valid_q[idx_q]) begin
          if (grp != my_group_q || rd_data_q.age > alim_q) valid_d[idx_q] = 1'b0;
          else size_d = size_q + CW'(1);
        end
        idx_d = idx_q + AW'(1);
      end
      ggvt_pkg::S_END_ADJ: begin
        if (size_p1 < CmpW'(rmin_q) && groups_q > GW'(1)) t_grp = groups_q >> 1;
        if (size_p1 > CmpW'(rmax_q)) begin
          dbl   = {t_grp, 1'b0};
          t_grp = (dbl > (GW + 1)'(ggvt_pkg::MAX_GROUPS)) ? GW'(ggvt_pkg::MAX_GROUPS)
                                                         : GW'(dbl);
        end
        if (first_q) begin
          t_grp   = (seen_q > GW'(ggvt_pkg::MAX_GROUPS)) ? GW'(ggvt_pkg::MAX_GROUPS) : seen_q;
          if (t_grp == '0) t_grp = GW'(1);
          first_d = 1'b0;
        end
        groups_d = t_grp;
      end
      ggvt_pkg::S_SELF_FIN: my_group_d = grp;
      ggvt_pkg::S_EMIT: if (out_load) out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ggvt_pkg::S_IDLE;
      valid_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      size_q      <= '0;
      groups_q    <= GW'(1);
      my_group_q  <= GW'(1);
      seen_q      <= GW'(1);
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      rmin_q      <= 8'd1;
      rmax_q      <= 8'd8;
      alim_q      <= 8'd20;
      self_id_q   <= '0;
      self_pos_q  <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      free_q      <= free_d;
      size_q      <= size_d;
      groups_q    <= groups_d;
      my_group_q  <= my_group_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ggvt_pkg::CFG_REPL_MIN) rmin_q     <= cfg_wdata_i[7:0];
        if (cfg_idx_i == ggvt_pkg::CFG_REPL_MAX) rmax_q     <= cfg_wdata_i[7:0];
        if (cfg_idx_i == ggvt_pkg::CFG_AGE_LIM)  alim_q     <= cfg_wdata_i[7:0];
        if (cfg_idx_i == ggvt_pkg::CFG_SELF_ID)  self_id_q  <= cfg_wdata_i[15:0];
        if (cfg_idx_i == ggvt_pkg::CFG_SELF_POS) self_pos_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (out_load) begin
      out_gc_q   <= groups_q;
      out_own_q  <= my_group_q;
      out_size_q <= ggvt_pkg::VIEW_SIZE_W'(size_q);
    end
  end

  // view memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[idx_q];
  end

`ifndef SYNTHESIS
  a_size_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ggvt_pkg::S_END_ADJ) |-> (32'(size_q) == $countones(valid_q)))
    else $error("view size does not match valid entries");
  a_out_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_gc_q != '0 && out_gc_q <= GW'(ggvt_pkg::MAX_GROUPS)))
    else $error("group count out of range");
  a_out_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_own_q != '0 && out_own_q <= out_gc_q))
    else $error("own group out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted while busy");
`endif

endmodule

[dv/gossip_group_view_table_checker.sv]
// checker for the gossip group view table: watches both streams, predicts the view
// and compares every result transaction; depends on ggvt_pkg
`timescale 1ns / 1ps
module gossip_group_view_table_checker #(
  parameter int VIEW_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ggvt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ggvt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [ggvt_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [ggvt_pkg::OUT_DATA_W-1:0]   m_tdata,
  output int                                errors_o,
  output int                                pending_o
);

  typedef struct packed {
    logic [ggvt_pkg::GROUP_W-1:0]     gc;
    logic [ggvt_pkg::GROUP_W-1:0]     grp;
    logic [ggvt_pkg::VIEW_SIZE_W-1:0] size;
  } view_result_t;

  logic [7:0]                   repl_min, repl_max, age_lim;
  logic [ggvt_pkg::IDENT_W-1:0] my_id;
  logic [ggvt_pkg::POS_W-1:0]   my_pos;
  logic                         v_ok  [VIEW_DEPTH];
  logic [ggvt_pkg::KEY_W-1:0]   v_key [VIEW_DEPTH];
  logic [ggvt_pkg::IDENT_W-1:0] v_id  [VIEW_DEPTH];
  logic [ggvt_pkg::AGE_W-1:0]   v_age [VIEW_DEPTH];
  logic [ggvt_pkg::POS_W-1:0]   v_pos [VIEW_DEPTH];
  int unsigned                  groups, my_grp, seen;
  logic                         first;
  view_result_t                 results_due[$];

  assign pending_o = results_due.size();

  function automatic int unsigned group_of(logic [ggvt_pkg::POS_W-1:0] pos);
    longint unsigned one, p, g;
    one = 64'd1 << ggvt_pkg::POS_FRAC;
    p = (pos > one) ? one : pos;
    g = (longint'(groups) * p + one - 1) >> ggvt_pkg::POS_FRAC;
    return (g == 0) ? 1 : int'(g);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic merge_record(logic [ggvt_pkg::IN_DATA_W-1:0] d, bit local_rec);
    logic [ggvt_pkg::KEY_W-1:0]   k;
    logic [ggvt_pkg::IDENT_W-1:0] id;
    logic [ggvt_pkg::AGE_W-1:0]   a;
    logic [ggvt_pkg::POS_W-1:0]   p;
    int at;
    k = d[15:0]; id = d[31:16]; a = d[39:32]; p = d[56:40];
    if (group_of(p) != my_grp || id == my_id) return;
    at = -1;
    for (int i = 0; i < VIEW_DEPTH; i++)
      if (at < 0 && v_ok[i] && v_key[i] == k) at = i;
    if (at >= 0) begin
      if (v_age[at] > a) begin
        v_age[at] = a;
        if (!local_rec) begin
          v_id[at] = id;
          v_pos[at] = p;
        end
      end
      return;
    end
    for (int i = 0; i < VIEW_DEPTH; i++)
      if (at < 0 && !v_ok[i]) at = i;
    if (at < 0) return;
    v_ok[at] = 1'b1; v_key[at] = k; v_id[at] = id; v_age[at] = a; v_pos[at] = p;
  endtask

  task automatic close_message();
    int unsigned n;
    view_result_t r;
    n = 0;
    for (int i = 0; i < VIEW_DEPTH; i++)
      if (v_ok[i]) begin
        if (group_of(v_pos[i]) != my_grp || v_age[i] > age_lim) v_ok[i] = 1'b0;
        else n++;
      end
    if (n + 1 < repl_min && groups > 1) groups = groups / 2;
    if (n + 1 > repl_max)
      groups = (groups * 2 > ggvt_pkg::MAX_GROUPS) ? ggvt_pkg::MAX_GROUPS : groups * 2;
    if (first) begin
      groups = (seen > ggvt_pkg::MAX_GROUPS) ? ggvt_pkg::MAX_GROUPS : seen;
      if (groups == 0) groups = 1;
      first = 1'b0;
    end
    my_grp = group_of(my_pos);
    r.gc   = ggvt_pkg::GROUP_W'(groups);
    r.grp  = ggvt_pkg::GROUP_W'(my_grp);
    r.size = ggvt_pkg::VIEW_SIZE_W'(n);
    results_due = {results_due, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_min = 8'd1; repl_max = 8'd8; age_lim = 8'd20; my_id = '0; my_pos = '0;
      for (int i = 0; i < VIEW_DEPTH; i++) v_ok[i] = 1'b0;
      groups = 1; my_grp = 1; seen = 1; first = 1'b1;
      errors_o = 0;
      results_due.delete();
    end else begin
      if (cfg_we_i)
        case (cfg_idx_i)
          ggvt_pkg::CFG_REPL_MIN: repl_min = cfg_wdata_i[7:0];
          ggvt_pkg::CFG_REPL_MAX: repl_max = cfg_wdata_i[7:0];
          ggvt_pkg::CFG_AGE_LIM:  age_lim  = cfg_wdata_i[7:0];
          ggvt_pkg::CFG_SELF_ID:  my_id    = cfg_wdata_i[15:0];
          ggvt_pkg::CFG_SELF_POS: my_pos   = cfg_wdata_i[16:0];
          default: ;
        endcase
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          view_result_t w, g;
          w = results_due.pop_front();
          g.gc = m_tdata[10:0]; g.grp = m_tdata[21:11]; g.size = m_tdata[27:22];
          if (g.gc != w.gc) report("group_count", g.gc, w.gc);
          if (g.grp != w.grp) report("own_group", g.grp, w.grp);
          if (g.size != w.size) report("view_size", g.size, w.size);
          if (m_tdata[31:28] != 0) report("pad", m_tdata[31:28], 0);
        end
      end
      if (s_tvalid && s_tready)
        case (ggvt_pkg::op_e'(s_tuser))
          ggvt_pkg::OP_START: begin
            for (int i = 0; i < VIEW_DEPTH; i++)
              if (v_ok[i] && v_age[i] != ggvt_pkg::AGE_MAX)
                v_age[i] = v_age[i] + ggvt_pkg::AGE_W'(1);
            seen = 1;
          end
          ggvt_pkg::OP_PEER: begin
            if (first && s_tdata[67:57] > groups) seen = 32'(s_tdata[67:57]);
            merge_record(s_tdata, 1'b0);
          end
          ggvt_pkg::OP_LOCAL: merge_record(s_tdata, 1'b1);
          default: close_message();
        endcase
    end
  end

endmodule

[dv/gossip_group_view_table_test.sv]
// stimulus top for the gossip group view table: clock, reset, config phases,
// directed and random gossip messages; depends on ggvt_pkg, the table and the checker
`timescale 1ns / 1ps
module gossip_group_view_table_test;

  logic                            clk_i, rst_ni;
  logic                            cfg_we_i;
  logic [ggvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ggvt_pkg::CFG_W-1:0]      cfg_wdata_i;
  logic                            s_axis_tvalid, s_axis_tready;
  logic [ggvt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]                      s_axis_tuser;
  logic                            m_axis_tvalid, m_axis_tready;
  logic [ggvt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  int                              errors, pending;
  int unsigned                     cycles;
  bit                              calm;
  logic [ggvt_pkg::KEY_W-1:0]      key_pool[8];

  gossip_group_view_table u_top (.*);

  gossip_group_view_table_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
    .s_tuser(s_axis_tuser), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 6);

  task automatic send(ggvt_pkg::op_e op, logic [15:0] k, logic [15:0] id, logic [7:0] a,
                      logic [16:0] p, logic [10:0] gc);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, gc, p, a, id, k};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [ggvt_pkg::CFG_IDX_W-1:0] idx, logic [ggvt_pkg::CFG_W-1:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic rand_record(ggvt_pkg::op_e op, bit wide);
    logic [16:0] p;
    p = ($urandom_range(15) == 0) ? 17'($urandom_range(131071, 65536))
                                  : 17'($urandom_range(65536));
    send(op, wide ? 16'($urandom) : key_pool[$urandom_range(7)], 16'($urandom),
         8'($urandom_range(30)), p, 11'($urandom_range(2047)));
  endtask

  task automatic gossip_message(bit wide);
    int n;
    n = $urandom_range(wide ? 40 : 6);
    send(ggvt_pkg::OP_START, '0, '0, '0, '0, '0);
    for (int i = 0; i < n; i++)
      rand_record($urandom_range(4) == 0 ? ggvt_pkg::OP_LOCAL : ggvt_pkg::OP_PEER, wide);
    send(ggvt_pkg::OP_END, '0, '0, '0, '0, '0);
  endtask

  initial begin
    calm = 0; cycles = 0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // end before start, records before start
    send(ggvt_pkg::OP_END, '0, '0, '0, '0, '0);
    send(ggvt_pkg::OP_PEER, 16'hFFFF, 16'hFFFF, 8'hFF, 17'h1FFFF, 11'h7FF);
    send(ggvt_pkg::OP_PEER, 16'h0000, 16'h0001, 8'h00, 17'd0, 11'd1);
    send(ggvt_pkg::OP_LOCAL, 16'h0000, 16'h0001, 8'h00, 17'd65536, 11'd0);
    send(ggvt_pkg::OP_PEER, 16'h0001, 16'h0000, 8'h05, 17'd100, 11'd2);
    send(ggvt_pkg::OP_START, '0, '0, '0, '0, '0);
    send(ggvt_pkg::OP_PEER, 16'h0002, 16'h0002, 8'hFF, 17'd65536, 11'd1024);
    send(ggvt_pkg::OP_PEER, 16'h0002, 16'h0003, 8'h01, 17'd1, 11'd3);
    send(ggvt_pkg::OP_LOCAL, 16'h0002, 16'h0004, 8'h00, 17'd2, 11'd0);
    send(ggvt_pkg::OP_END, '0, '0, '0, '0, '0);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(ggvt_pkg::CFG_REPL_MIN, 17'd1);
                 write_reg(ggvt_pkg::CFG_REPL_MAX, 17'd255);
                 write_reg(ggvt_pkg::CFG_AGE_LIM, 17'd255);
                 write_reg(ggvt_pkg::CFG_SELF_ID, 17'hFFFF);
                 write_reg(ggvt_pkg::CFG_SELF_POS, 17'd65536); end
        1: begin write_reg(ggvt_pkg::CFG_REPL_MIN, 17'd255);
                 write_reg(ggvt_pkg::CFG_REPL_MAX, 17'd1);
                 write_reg(ggvt_pkg::CFG_AGE_LIM, 17'd0);
                 write_reg(ggvt_pkg::CFG_SELF_ID, 17'd0);
                 write_reg(ggvt_pkg::CFG_SELF_POS, 17'd0); end
        2: begin write_reg(ggvt_pkg::CFG_REPL_MIN, 17'd3);
                 write_reg(ggvt_pkg::CFG_REPL_MAX, 17'd6);
                 write_reg(ggvt_pkg::CFG_AGE_LIM, 17'd20);
                 write_reg(ggvt_pkg::CFG_SELF_POS, 17'h1FFFF); end
        default: begin
          write_reg(ggvt_pkg::CFG_REPL_MIN, 17'($urandom_range(1, 10)));
          write_reg(ggvt_pkg::CFG_REPL_MAX, 17'($urandom_range(1, 40)));
          write_reg(ggvt_pkg::CFG_AGE_LIM, 17'($urandom_range(255)));
          write_reg(ggvt_pkg::CFG_SELF_ID, 17'($urandom_range(65535)));
          write_reg(ggvt_pkg::CFG_SELF_POS, 17'($urandom_range(65536)));
        end
      endcase
      calm = (phase == 3);
      for (int m = 0; m < 15; m++) begin
        if ($urandom_range(9) == 0) rand_record(ggvt_pkg::op_e'($urandom_range(3)), 1);
        else gossip_message($urandom_range(3) == 0);
      end
      drain();
    end
    calm = 0;
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
